>>> rtl/mabs_pkg.sv
// shared constants, types and helpers for the moving average band signal block
package mabs_pkg;

  localparam int MAX_WINDOW    = 64;
  localparam int SAMPLE_BITS   = 32;
  localparam int LEN_BITS      = 7;
  localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
  localparam int SUM_BITS      = 38;
  localparam int TOL_BITS      = 16;
  localparam int SIG_BITS      = 2;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int LHS_BITS      = SAMPLE_BITS + LEN_BITS;
  localparam int FACTOR_BITS   = TOL_BITS + 1;
  localparam int PROD_BITS     = SUM_BITS + FACTOR_BITS;

  localparam logic [LEN_BITS-1:0]    LEN_RESET = LEN_BITS'(8);
  localparam logic [LEN_BITS-1:0]    LEN_MAX   = LEN_BITS'(MAX_WINDOW);
  localparam logic [TOL_BITS-1:0]    TOL_RESET = TOL_BITS'(3277);
  localparam logic [FACTOR_BITS-1:0] ONE_Q16   = FACTOR_BITS'(1) << TOL_BITS;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE  = CFG_IDX_BITS'(1);

  // signal codes
  localparam logic [SIG_BITS-1:0] SIG_NONE = SIG_BITS'(0);
  localparam logic [SIG_BITS-1:0] SIG_BUY  = SIG_BITS'(1);
  localparam logic [SIG_BITS-1:0] SIG_SELL = SIG_BITS'(2);

  // item leaving the window stage, sum is the running sum after this sample
  typedef struct packed {
    logic                   valid;
    logic [SAMPLE_BITS-1:0] newest;
    logic [LEN_BITS-1:0]    len;
    logic [TOL_BITS-1:0]    tol;
    logic [SUM_BITS-1:0]    sum;
  } win_item_t;

  // zero means one, anything above the ring depth saturates
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] wl);
    logic [LEN_BITS-1:0] r;
    if (wl == '0) r = LEN_BITS'(1);
    else if (wl > LEN_MAX) r = LEN_MAX;
    else r = wl;
    return r;
  endfunction

endpackage

>>> rtl/mabs_if.sv
// channel interfaces: sample input, result output, configuration writes
interface mabs_sample_if import mabs_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mabs_result_if import mabs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] window_sum;
  logic [SIG_BITS-1:0] signal;
  modport source (output valid, output window_sum, output signal, input ready);
  modport sink (input valid, input window_sum, input signal, output ready);
endinterface

interface mabs_cfg_if import mabs_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/mabs_window.sv
// sample ring, fill tracking and running sum
module mabs_window import mabs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   take,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   restart,
  input  logic [LEN_BITS-1:0]    len,
  input  logic [TOL_BITS-1:0]    tol,
  output win_item_t              item
);

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] old_sample;

  logic [LEN_BITS-1:0]  fill_count;
  logic [LEN_BITS-1:0]  fill_count_next;
  logic [SLOT_BITS-1:0] write_slot;
  logic [SLOT_BITS-1:0] write_slot_next;
  logic [SLOT_BITS-1:0] slot;
  logic [LEN_BITS-1:0]  slot_inc;
  logic                 full;
  logic                 has_result;

  logic                   s1_valid;
  logic                   s1_sub;
  logic                   s1_res;
  logic [SAMPLE_BITS-1:0] s1_newest;
  logic [LEN_BITS-1:0]    s1_len;
  logic [TOL_BITS-1:0]    s1_tol;

  logic                   s2_valid;
  logic [SAMPLE_BITS-1:0] s2_newest;
  logic [LEN_BITS-1:0]    s2_len;
  logic [TOL_BITS-1:0]    s2_tol;
  logic [SUM_BITS-1:0]    running_sum;
  logic [SAMPLE_BITS-1:0] drop;

  always_comb begin
    slot            = (LEN_BITS'(write_slot) < len) ? write_slot : '0;
    slot_inc        = LEN_BITS'(slot) + LEN_BITS'(1);
    write_slot_next = (slot_inc >= len) ? '0 : slot_inc[SLOT_BITS-1:0];
    full            = (fill_count >= len);
    fill_count_next = full ? len : fill_count + LEN_BITS'(1);
    has_result      = (fill_count_next >= len);
  end

  // read-first ring: old entry comes out as the new one goes in
  always_ff @(posedge clk) begin
    if (take) begin
      old_sample <= ring[slot];
      ring[slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      write_slot <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (restart) begin
        fill_count <= '0;
        write_slot <= '0;
      end else if (take) begin
        fill_count <= fill_count_next;
        write_slot <= write_slot_next;
      end
      if (advance) s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sub    <= full;
      s1_res    <= has_result;
      s1_newest <= sample;
      s1_len    <= len;
      s1_tol    <= tol;
    end
  end

  assign drop = s1_sub ? old_sample : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      s2_valid    <= 1'b0;
    end else begin
      if (restart) begin
        running_sum <= '0;
      end else if (advance && s1_valid) begin
        running_sum <= running_sum - SUM_BITS'(drop) + SUM_BITS'(s1_newest);
      end
      if (advance) s2_valid <= s1_valid && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_newest <= s1_newest;
      s2_len    <= s1_len;
      s2_tol    <= s1_tol;
    end
  end

  assign item = '{valid: s2_valid, newest: s2_newest, len: s2_len, tol: s2_tol,
                  sum: running_sum};

endmodule

>>> rtl/mabs_band.sv
// band products, compare and result register
module mabs_band import mabs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  win_item_t           item,
  output logic                out_valid,
  output logic [SUM_BITS-1:0] window_sum,
  output logic [SIG_BITS-1:0] signal
);

  logic [FACTOR_BITS-1:0] lo_factor;
  logic [FACTOR_BITS-1:0] hi_factor;

  logic                 s3_valid;
  logic [LHS_BITS-1:0]  s3_lhs;
  logic [PROD_BITS-1:0] s3_lo;
  logic [PROD_BITS-1:0] s3_hi;
  logic [SUM_BITS-1:0]  s3_sum;

  logic [PROD_BITS-1:0] lhs_q16;
  logic [SIG_BITS-1:0]  sig;

  assign lo_factor = ONE_Q16 - FACTOR_BITS'(item.tol);
  assign hi_factor = ONE_Q16 + FACTOR_BITS'(item.tol);

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (advance) s3_valid <= item.valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_lhs <= LHS_BITS'(item.newest) * LHS_BITS'(item.len);
      s3_lo  <= PROD_BITS'(item.sum) * PROD_BITS'(lo_factor);
      s3_hi  <= PROD_BITS'(item.sum) * PROD_BITS'(hi_factor);
      s3_sum <= item.sum;
    end
  end

  // newest*len scaled by 2^16 against the two band edges
  always_comb begin
    lhs_q16 = {PROD_BITS'(s3_lhs)} << TOL_BITS;
    if (s3_sum == '0) sig = SIG_NONE;
    else if (lhs_q16 < s3_lo) sig = SIG_BUY;
    else if (lhs_q16 > s3_hi) sig = SIG_SELL;
    else sig = SIG_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      window_sum <= s3_sum;
      signal     <= sig;
    end
  end

endmodule

>>> rtl/moving_average_band_signal.sv
// top level of the moving average band signal block
//
//   channel     dir  handshake      payload
//   sample_ch   in   valid/ready    sample[31:0]
//   result_ch   out  valid/ready    window_sum[37:0], signal[1:0]
//   cfg         in   valid/ready    index[3:0], data[15:0]
//
// one sample per cycle sustained while no result stalls; a result leaves after
// ring read/write, running sum, band products, compare into the output register
// the ring is a single-port read-first memory, so the entry being replaced is read
// at the same edge the new sample is written, and the sum needs no forwarding
// a stalled result freezes the whole pipe, ready follows the output register
// synchronous reset clears control, the sum and the registers (length 8, tol 3277)
module moving_average_band_signal import mabs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mabs_sample_if.sink  sample_ch,
  mabs_result_if.source result_ch,
  mabs_cfg_if.sink     cfg
);

  logic [LEN_BITS-1:0] window_len;
  logic [TOL_BITS-1:0] tolerance_q16;
  logic                advance;
  logic                take;
  logic                cfg_write;
  logic                restart;
  win_item_t           item;

  // pipe moves whenever the output register is empty or being drained
  assign advance         = !result_ch.valid || result_ch.ready;
  assign sample_ch.ready = advance;
  assign take            = sample_ch.valid && advance;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;
  // a new window length restarts the window
  assign restart   = cfg_write && (cfg.index == REG_WINDOW_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= LEN_RESET;
      tolerance_q16 <= TOL_RESET;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_WINDOW_LEN: window_len    <= cfg.data[LEN_BITS-1:0];
        REG_TOLERANCE:  tolerance_q16 <= cfg.data[TOL_BITS-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // ring, fill count and running sum
  mabs_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .take    (take),
    .sample  (sample_ch.sample),
    .restart (restart),
    .len     (eff_len(window_len)),
    .tol     (tolerance_q16),
    .item    (item)
  );

  // products against the band edges and the result register
  mabs_band u_band (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .out_valid  (result_ch.valid),
    .window_sum (result_ch.window_sum),
    .signal     (result_ch.signal)
  );

endmodule

>>> rtl/mabs_checker.sv
// port-level checks for the moving average band signal block, with its bind
module mabs_checker import mabs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SUM_BITS-1:0] window_sum,
  input logic [SIG_BITS-1:0] signal
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_sum) && $stable(signal))
    else $error("result changed while stalled");

  // buy and sell never both
  a_sig_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (signal == SIG_NONE || signal == SIG_BUY || signal == SIG_SELL))
    else $error("bad signal code");

  // an empty window sum never raises a signal
  a_zero_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && (window_sum == '0) |-> signal == SIG_NONE)
    else $error("signal on zero sum");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind moving_average_band_signal mabs_checker u_mabs_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .window_sum (result_ch.window_sum),
  .signal     (result_ch.signal)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the moving average band signal block
module testbench;
  import mabs_pkg::*;

  // results pass the pipe registers after their transfer; wait past that before a register write
  localparam int SETTLE_CYCLES = 10;
  // long receiver hold-off, long enough to fill the pipe and stall the sample input
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1050;
  // from here on neither side idles
  localparam int CALM_FROM     = 900;
  localparam int MAX_PRINTS    = 100;
  // an index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(15);

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [SIG_BITS-1:0] sig;
  } band_t;

  // one row of the directed plan: either a sample or a register write
  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic [SAMPLE_BITS-1:0]   smp;
    logic                     typed;
    band_t                    want;
  } row_t;

  localparam int PLAN_ROWS = 26;

  // typed expectations are the ones that follow directly from the window contents
  row_t plan [PLAN_ROWS] = '{
    // reset length 8, tolerance 3277: seven samples fill, the eighth has a zero sum
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b1, '{38'h0, SIG_NONE}},
    // max sample alone in an eight-wide window, eight times the average
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'hFFFF_FFFF, 1'b1,
      '{38'h0_FFFF_FFFF, SIG_SELL}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h1234_5678, 1'b0, '{38'h0, SIG_NONE}},
    // length zero with upper data bits set acts as length one
    '{ROW_CONFIG, REG_WINDOW_LEN, 16'hFF80, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'hFFFF_FFFF, 1'b1,
      '{38'h0_FFFF_FFFF, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b1, '{38'h0, SIG_NONE}},
    // zero tolerance, ratio exactly one sits on both edges
    '{ROW_CONFIG, REG_TOLERANCE,  16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0005, 1'b1, '{38'h5, SIG_NONE}},
    // length two, widest band
    '{ROW_CONFIG, REG_WINDOW_LEN, 16'h0002, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_CONFIG, REG_TOLERANCE,  16'hFFFF, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'hFFFF_FFFF, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b1,
      '{38'h0_FFFF_FFFF, SIG_BUY}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'hFFFF_FFFF, 1'b1,
      '{38'h0_FFFF_FFFF, SIG_SELL}},
    // write past the register list: window must survive
    '{ROW_CONFIG, REG_UNUSED,     16'h0003, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'hFFFF_FFFF, 1'b1,
      '{38'h1_FFFF_FFFE, SIG_NONE}},
    // tolerance write keeps the window
    '{ROW_CONFIG, REG_TOLERANCE,  16'h0000, 32'h0000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h0000_0000, 1'b1,
      '{38'h0_FFFF_FFFF, SIG_BUY}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h8000_0000, 1'b0, '{38'h0, SIG_NONE}},
    '{ROW_SAMPLE, REG_WINDOW_LEN, 16'h0000, 32'h7FFF_FFFF, 1'b0, '{38'h0, SIG_NONE}}
  };

  logic clk;
  logic rst;

  mabs_sample_if sample_ch ();
  mabs_result_if result_ch ();
  mabs_cfg_if    cfg_ch ();

  moving_average_band_signal u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg       (cfg_ch)
  );

  // window shadow: ring, running sum, fill level, next slot and the two registers
  logic [SAMPLE_BITS-1:0] win_ring [MAX_WINDOW];
  logic [63:0]            win_sum;
  int                     win_fill;
  int                     win_slot;
  logic [LEN_BITS-1:0]    win_len_reg;
  logic [TOL_BITS-1:0]    win_tol_reg;

  // bands still owed by the block, oldest first
  band_t awaited_bands [$];

  int mismatches;
  int results_seen;
  int idle_pct;       // chance of an idle burst, shared by both sides
  int hold_asks;      // bumped by the stimulus to ask for one long hold-off
  int hold_seen;
  int hold_left;
  int stall_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // end the run if the block hangs
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // zero means one, past the ring depth saturates
  function automatic int eff_window();
    int len;
    if (win_len_reg == '0) len = 1;
    else if (win_len_reg > MAX_WINDOW) len = MAX_WINDOW;
    else len = int'(win_len_reg);
    return len;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_WINDOW_LEN: begin
        // new length restarts the window
        win_len_reg = data[LEN_BITS-1:0];
        win_sum     = '0;
        win_fill    = 0;
        win_slot    = 0;
      end
      REG_TOLERANCE: win_tol_reg = data[TOL_BITS-1:0];
      default: ;
    endcase
  endfunction

  // push one sample into the shadow window, returns 1 when the window is full
  function automatic bit advance_window(input logic [SAMPLE_BITS-1:0] s, output band_t res);
    int          len;
    int          slot;
    logic [63:0] lhs;
    logic [63:0] lo_edge;
    logic [63:0] hi_edge;
    len  = eff_window();
    slot = (win_slot < len) ? win_slot : 0;
    if (win_fill >= len) begin
      win_sum  = win_sum - 64'(win_ring[slot]);
      win_fill = len;
    end else begin
      win_fill++;
    end
    win_ring[slot] = s;
    win_sum        = win_sum + 64'(s);
    win_slot       = (slot + 1 >= len) ? 0 : slot + 1;
    res.sum = win_sum[SUM_BITS-1:0];
    res.sig = SIG_NONE;
    if (win_fill < len) return 1'b0;
    // products stay below 2^55, so 64 bits hold them exactly
    if (win_sum != '0) begin
      lhs     = (64'(s) * 64'(len)) << 16;
      lo_edge = win_sum * (64'd65536 - 64'(win_tol_reg));
      hi_edge = win_sum * (64'd65536 + 64'(win_tol_reg));
      if (lhs < lo_edge) res.sig = SIG_BUY;
      else if (lhs > hi_edge) res.sig = SIG_SELL;
    end
    return 1'b1;
  endfunction

  // half the values around the phase base, the rest random, zero or max, so that all three signals come up
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] base);
    logic [SAMPLE_BITS-1:0] span;
    logic [SAMPLE_BITS-1:0] delta;
    logic [SAMPLE_BITS-1:0] s;
    int                     kind;
    kind  = $urandom_range(0, 9);
    span  = base >> $urandom_range(1, 14);
    delta = $urandom_range(0, span);
    case (kind)
      0, 1, 2: s = $urandom;
      3:       s = '0;
      4:       s = '1;
      default: begin
        if ($urandom_range(0, 1) == 0 || delta > ~base) s = base - delta;
        else s = base + delta;
      end
    endcase
    return s;
  endfunction

  // called and returning at a falling edge; valid is left high for the next item
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic typed,
                             input band_t typed_band);
    band_t predicted;
    bit    produced;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
    produced = advance_window(s, predicted);
    if (produced)
      awaited_bands.insert(awaited_bands.size(), typed ? typed_band : predicted);
    @(negedge clk);
  endtask

  // register writes only with the block drained and settled
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    while (awaited_bands.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver: short random stalls, plus one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 9) - 1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // every result transfer is matched against the oldest owed band
  always @(posedge clk) begin : result_check
    band_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_bands.size() == 0) begin
        report_mismatch($sformatf("unexpected result sum %0h signal %0d",
                                  result_ch.window_sum, result_ch.signal));
      end else begin
        want = awaited_bands.pop_front();
        if (result_ch.window_sum !== want.sum)
          report_mismatch($sformatf("window_sum %0h, want %0h", result_ch.window_sum, want.sum));
        if (result_ch.signal !== want.sig)
          report_mismatch($sformatf("signal %0d, want %0d", result_ch.signal, want.sig));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int                     sent;
    int                     phase;
    int                     n_items;
    int                     mode;
    logic [LEN_BITS-1:0]    len_val;
    logic [TOL_BITS-1:0]    tol_val;
    logic [SAMPLE_BITS-1:0] base;
    bit                     flat_max;

    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    mismatches       = 0;
    results_seen     = 0;
    hold_asks        = 0;
    idle_pct         = 20;

    // shadow state as after reset
    for (int i = 0; i < MAX_WINDOW; i++) win_ring[i] = '0;
    win_sum     = '0;
    win_fill    = 0;
    win_slot    = 0;
    win_len_reg = LEN_RESET;
    win_tol_reg = TOL_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        sample_ch.valid <= 1'b0;
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end
    end
    sample_ch.valid <= 1'b0;

    // random phases, each with its own register setting
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      flat_max = 1'b0;
      // fixed phases always set the length
      mode     = 2;
      case (phase)
        0: begin
          // widest window full of max samples: largest sum
          len_val  = LEN_BITS'(MAX_WINDOW);
          tol_val  = '0;
          flat_max = 1'b1;
        end
        1: begin
          // length past the ring depth saturates
          len_val = '1;
          tol_val = '1;
        end
        2: begin
          len_val = LEN_BITS'(1);
          tol_val = TOL_BITS'($urandom_range(0, 4000));
        end
        default: begin
          case ($urandom_range(0, 9))
            7:       len_val = LEN_BITS'($urandom_range(13, MAX_WINDOW));
            8:       len_val = ($urandom_range(0, 1) == 0) ? '0 : LEN_BITS'($urandom_range(65, 127));
            9:       len_val = LEN_BITS'(MAX_WINDOW);
            default: len_val = LEN_BITS'($urandom_range(1, 12));
          endcase
          case ($urandom_range(0, 3))
            0:       tol_val = TOL_BITS'($urandom_range(0, 2000));
            1:       tol_val = TOL_BITS'($urandom_range(2000, 20000));
            2:       tol_val = TOL_BITS'($urandom);
            default: tol_val = ($urandom_range(0, 1) == 0) ? '0 : '1;
          endcase
          mode = $urandom_range(0, 5);
        end
      endcase

      // mode 0 keeps the window and only moves the band, mode 1 adds a dropped write
      if (mode == 1) write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
      if (mode != 0)
        write_reg(REG_WINDOW_LEN, {CFG_DATA_BITS'($urandom_range(0, 511)) << LEN_BITS} |
                                  CFG_DATA_BITS'(len_val));
      write_reg(REG_TOLERANCE, CFG_DATA_BITS'(tol_val));

      if (sent >= CALM_FROM) idle_pct = 0;
      else idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);

      // receiver holds off while the sender keeps offering
      if (phase == 2) hold_asks++;

      base    = $urandom >> $urandom_range(0, 31);
      n_items = (eff_window() > 32) ? 110 : 70;
      for (int k = 0; k < n_items && sent < RANDOM_ITEMS; k++) begin
        send_sample(flat_max ? '1 : pick_sample(base), 1'b0, '{'0, SIG_NONE});
        sent++;
      end
      sample_ch.valid <= 1'b0;
      phase++;
    end

    // drain, then give stray results time to show up
    while (awaited_bands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
